// ----- hw/rtl/m3i_pkg.sv -----
// Shared types, widths and cofactor index tables for the 3x3 matrix inverse.
package m3i_pkg;

   // Fixed field widths
   localparam int ENT_W = 32;
   localparam int PROD_W = 2 * ENT_W;
   localparam int COF_W = PROD_W + 1;
   localparam int MAG_W = PROD_W;
   localparam int DET_W = ENT_W + COF_W + 1;
   localparam int Q_BITS = 32;
   localparam int N_ENT = 9;

   // Defaults for top-level parameters
   localparam int FRAC_BITS_DEF = 16;
   localparam int QUEUE_DEPTH = 4;

   // Saturation values
   localparam logic [Q_BITS-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [Q_BITS-1:0] SAT_MIN = 32'h8000_0000;

   typedef logic [3:0] idx_type;

   // Transposed cofactor k is e[A]*e[B] - e[C]*e[D]
   localparam idx_type COF_A [N_ENT] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
   localparam idx_type COF_B [N_ENT] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
   localparam idx_type COF_C [N_ENT] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
   localparam idx_type COF_D [N_ENT] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

   // Classified item handed from the front to the divider
   typedef struct packed {
      logic [N_ENT-1:0][MAG_W-1:0] mag;
      logic [N_ENT-1:0]            neg;
      logic [DET_W-1:0]            dmag;
      logic                        singular;
   } item_type;

endpackage

// ----- hw/rtl/m3i_front.sv -----
// Front pipeline: accept a matrix, form cofactors and determinant, classify.
module m3i_front (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_stall,
   input  logic [m3i_pkg::N_ENT-1:0][m3i_pkg::ENT_W-1:0] ent,
   input  logic                                          q_full,
   output logic                                          push,
   output m3i_pkg::item_type                             push_item
);
   import m3i_pkg::*;

   localparam int NF = 7;
   localparam int EXT_W = DET_W - COF_W;

   logic                     adv;
   logic [NF-1:0]            fv_ff;
   logic signed [ENT_W-1:0]  ent_ff [N_ENT];
   logic signed [PROD_W-1:0] pab_ff [N_ENT];
   logic signed [PROD_W-1:0] pcd_ff [N_ENT];
   logic signed [ENT_W-1:0]  ent1_ff [3];
   logic signed [COF_W-1:0]  cof2_ff [N_ENT];
   logic signed [ENT_W-1:0]  ent2_ff [3];
   logic signed [COF_W-1:0]  cof3_ff [N_ENT];
   logic signed [COF_W-1:0]  plo_ff [3];
   logic signed [COF_W-1:0]  phi_ff [3];
   logic signed [COF_W-1:0]  cof4_ff [N_ENT];
   logic signed [DET_W-1:0]  term_ff [3];
   logic signed [COF_W-1:0]  cof5_ff [N_ENT];
   logic signed [DET_W-1:0]  det_ff;
   item_type                 item_ff;
   item_type                 item_in;

   // Advance while the last stage is empty or the queue takes it
   assign adv = !fv_ff[NF-1] || !q_full;
   assign req_stall = !adv;
   assign push = fv_ff[NF-1] && !q_full;
   assign push_item = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (adv) begin
         fv_ff <= {fv_ff[NF-2:0], req_valid};
      end
   end

   // Classify: magnitudes, result signs, singular flag
   always_comb begin
      item_in.singular = (det_ff == '0);
      item_in.dmag = det_ff[DET_W-1] ? DET_W'(-det_ff) : DET_W'(det_ff);
      for (int k = 0; k < N_ENT; k++) begin
         item_in.neg[k] = cof5_ff[k][COF_W-1] ^ det_ff[DET_W-1];
         item_in.mag[k] = cof5_ff[k][COF_W-1] ? MAG_W'(-cof5_ff[k]) : MAG_W'(cof5_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // capture entries
         for (int k = 0; k < N_ENT; k++) begin
            ent_ff[k] <= $signed(ent[k]);
         end
         // cofactor products
         for (int k = 0; k < N_ENT; k++) begin
            pab_ff[k] <= ent_ff[COF_A[k]] * ent_ff[COF_B[k]];
            pcd_ff[k] <= ent_ff[COF_C[k]] * ent_ff[COF_D[k]];
         end
         for (int j = 0; j < 3; j++) begin
            ent1_ff[j] <= ent_ff[j];
            ent2_ff[j] <= ent1_ff[j];
         end
         // cofactor differences
         for (int k = 0; k < N_ENT; k++) begin
            cof2_ff[k] <= $signed({pab_ff[k][PROD_W-1], pab_ff[k]})
                        - $signed({pcd_ff[k][PROD_W-1], pcd_ff[k]});
            cof3_ff[k] <= cof2_ff[k];
            cof4_ff[k] <= cof3_ff[k];
            cof5_ff[k] <= cof4_ff[k];
         end
         // determinant partial products along the first row
         for (int j = 0; j < 3; j++) begin
            plo_ff[j] <= ent2_ff[j] * $signed({1'b0, cof2_ff[3*j][ENT_W-1:0]});
            phi_ff[j] <= ent2_ff[j] * $signed(cof2_ff[3*j][COF_W-1:ENT_W]);
         end
         // recombine halves: high part shifted up by one entry width
         for (int j = 0; j < 3; j++) begin
            term_ff[j] <= $signed({{(EXT_W-ENT_W){phi_ff[j][COF_W-1]}}, phi_ff[j],
                                   {ENT_W{1'b0}}})
                        + $signed({{EXT_W{plo_ff[j][COF_W-1]}}, plo_ff[j]});
         end
         det_ff <= term_ff[0] + term_ff[1] + term_ff[2];
         item_ff <= item_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (fv_ff[NF-1] && q_full))
      else $error("front stalls without a blocked item");
`endif

endmodule

// ----- hw/rtl/m3i_queue.sv -----
// Short queue of classified items between front and divider.
module m3i_queue #(
   parameter int DEPTH = m3i_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  m3i_pkg::item_type push_item,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output m3i_pkg::item_type head
);
   import m3i_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   item_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;

   assign full = (cnt_ff == CNT_W'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head = slot_ff[rd_ptr_ff];

   // Store pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");
`endif

endmodule

// ----- hw/rtl/m3i_back.sv -----
// Back pipeline: nine restoring dividers, one quotient bit per stage, then saturate.
module m3i_back #(
   parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           q_empty,
   output logic                                           pop,
   input  m3i_pkg::item_type                              head,
   output logic                                           rsp_valid,
   input  logic                                           rsp_stall,
   output logic [m3i_pkg::N_ENT-1:0][m3i_pkg::Q_BITS-1:0] res,
   output logic                                           rsp_singular,
   output logic                                           rsp_clipped
);
   import m3i_pkg::*;

   localparam int QB = Q_BITS;
   localparam int BIT_W = $clog2(QB);
   localparam int NUM_W = MAG_W + 2 * FRAC_BITS;
   localparam int DSH_W = DET_W + QB;
   localparam int DIV_W = ((NUM_W > DSH_W) ? NUM_W : DSH_W) + 1;

   logic                 adv;
   logic [QB:0]          bv_ff;
   logic [DIV_W-1:0]     rem_ff [QB+1][N_ENT];
   logic [DIV_W-1:0]     rem_in [QB+1][N_ENT];
   logic [QB-1:0]        quo_ff [QB+1][N_ENT];
   logic [QB-1:0]        quo_in [QB+1][N_ENT];
   logic [N_ENT-1:0]     ovf_ff [QB+1];
   logic [N_ENT-1:0]     ovf_in;
   logic [N_ENT-1:0]     neg_ff [QB+1];
   logic [DET_W-1:0]     den_ff [QB+1];
   logic                 sing_ff [QB+1];
   logic                 out_v_ff;
   logic [N_ENT-1:0][QB-1:0] res_ff;
   logic [N_ENT-1:0][QB-1:0] res_in;
   logic                 sing_out_ff;
   logic                 clip_ff;
   logic                 clip_in;

   // Advance whole pipe unless a finished item is held
   assign adv = !out_v_ff || !rsp_stall;
   assign pop = !q_empty && adv;
   assign rsp_valid = out_v_ff;
   assign res = res_ff;
   assign rsp_singular = sing_out_ff;
   assign rsp_clipped = clip_ff;

   // Division steps: load, then one quotient bit per stage
   always_comb begin
      logic [DIV_W-1:0] dsh;
      logic [DIV_W-1:0] dtop;
      logic             take;
      dtop = DIV_W'(head.dmag) << QB;
      for (int l = 0; l < N_ENT; l++) begin
         rem_in[0][l] = DIV_W'(head.mag[l]) << (2 * FRAC_BITS);
         quo_in[0][l] = '0;
         ovf_in[l] = (rem_in[0][l] >= dtop);
      end
      for (int s = 1; s <= QB; s++) begin
         for (int l = 0; l < N_ENT; l++) begin
            dsh = DIV_W'(den_ff[s-1]) << (QB - s);
            take = (rem_ff[s-1][l] >= dsh);
            rem_in[s][l] = take ? rem_ff[s-1][l] - dsh : rem_ff[s-1][l];
            quo_in[s][l] = quo_ff[s-1][l];
            quo_in[s][l][BIT_W'(QB - s)] = take;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= '0;
      end else if (adv) begin
         bv_ff <= {bv_ff[QB-1:0], !q_empty};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s <= QB; s++) begin
            for (int l = 0; l < N_ENT; l++) begin
               rem_ff[s][l] <= rem_in[s][l];
               quo_ff[s][l] <= quo_in[s][l];
            end
         end
         ovf_ff[0] <= ovf_in;
         neg_ff[0] <= head.neg;
         den_ff[0] <= head.dmag;
         sing_ff[0] <= head.singular;
         for (int s = 1; s <= QB; s++) begin
            ovf_ff[s] <= ovf_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
            den_ff[s] <= den_ff[s-1];
            sing_ff[s] <= sing_ff[s-1];
         end
      end
   end

   // Apply sign, saturate, zero out singular items
   always_comb begin
      logic [QB-1:0] q;
      clip_in = 1'b0;
      for (int l = 0; l < N_ENT; l++) begin
         q = quo_ff[QB][l];
         if (sing_ff[QB]) begin
            res_in[l] = '0;
         end else if (neg_ff[QB][l]) begin
            if (ovf_ff[QB][l] || q > SAT_MIN) begin
               res_in[l] = SAT_MIN;
               clip_in = 1'b1;
            end else begin
               res_in[l] = -q;
            end
         end else begin
            if (ovf_ff[QB][l] || q[QB-1]) begin
               res_in[l] = SAT_MAX;
               clip_in = 1'b1;
            end else begin
               res_in[l] = q;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= bv_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
         sing_out_ff <= sing_ff[QB];
         clip_ff <= clip_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_singular_unclipped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> (!rsp_clipped && res == '0))
      else $error("singular item with nonzero result");
   a_pop_enters: assert property (@(posedge clock) disable iff (reset)
      pop |=> bv_ff[0])
      else $error("popped item lost at divider entry");
`endif

endmodule

// ----- hw/rtl/matrix3_inverse.sv -----
// Top level of the 3x3 fixed-point matrix inverse.
//
//   channel  prefix  direction  payload
//   request  req_    in         m00..m22, signed Q16.16
//   response rsp_    out        r00..r22, singular, clipped
//
// One matrix is accepted per cycle and one result leaves per cycle while no stall holds them.
// An item passes the front pipeline, the queue, 33 divider stages and
// the output register; the divider stages hold the nine 32-step restoring dividers.
// Reset is synchronous and clears only valid bits and the queue pointers and count.
// A response stall freezes the divider; the front keeps filling the
// queue and stalls the request side only when the queue is full.
module matrix3_inverse #(
   parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH = m3i_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_m00,
   input  logic signed [31:0] req_m01,
   input  logic signed [31:0] req_m02,
   input  logic signed [31:0] req_m10,
   input  logic signed [31:0] req_m11,
   input  logic signed [31:0] req_m12,
   input  logic signed [31:0] req_m20,
   input  logic signed [31:0] req_m21,
   input  logic signed [31:0] req_m22,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_r00,
   output logic signed [31:0] rsp_r01,
   output logic signed [31:0] rsp_r02,
   output logic signed [31:0] rsp_r10,
   output logic signed [31:0] rsp_r11,
   output logic signed [31:0] rsp_r12,
   output logic signed [31:0] rsp_r20,
   output logic signed [31:0] rsp_r21,
   output logic signed [31:0] rsp_r22,
   output logic               rsp_singular,
   output logic               rsp_clipped
);
   import m3i_pkg::*;

   logic [N_ENT-1:0][ENT_W-1:0] ent;
   logic [N_ENT-1:0][Q_BITS-1:0] res;
   logic     q_full;
   logic     q_empty;
   logic     push;
   logic     pop;
   item_type push_item;
   item_type head;

   // Gather entries in row-major order
   assign ent = {req_m22, req_m21, req_m20, req_m12, req_m11, req_m10,
                 req_m02, req_m01, req_m00};

   m3i_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .ent       (ent),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   m3i_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .empty     (q_empty),
      .pop       (pop),
      .head      (head)
   );

   m3i_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .pop          (pop),
      .head         (head),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .res          (res),
      .rsp_singular (rsp_singular),
      .rsp_clipped  (rsp_clipped)
   );

   // Spread results onto ports
   assign rsp_r00 = $signed(res[0]);
   assign rsp_r01 = $signed(res[1]);
   assign rsp_r02 = $signed(res[2]);
   assign rsp_r10 = $signed(res[3]);
   assign rsp_r11 = $signed(res[4]);
   assign rsp_r12 = $signed(res[5]);
   assign rsp_r20 = $signed(res[6]);
   assign rsp_r21 = $signed(res[7]);
   assign rsp_r22 = $signed(res[8]);

endmodule
